// ===== design/dfb_pkg.sv =====
// Shared types and constants for the dirty-tracked frame buffer flush block.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package dfb_pkg;

  // Default panel geometry.
  localparam int PAGES_DEF = 8;
  localparam int COLS_DEF  = 64;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int KIND_W     = 2;

  // Result kinds carried on the master tuser.
  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd2;

  // Panel controller command bytes.
  localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
  localparam logic [7:0] CMD_SET_ADDR = 8'h40;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write one zero word of the clearing pass
    logic accept;   // a request is taken this cycle
    logic pix_wr;   // finish a pixel read-modify-write
    logic fl_eval;  // evaluate the dirty marks of the flush position
    logic emit;     // hand pending results to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // the clearing pass reaches its last word
    logic out_free;   // the output register can take a result this cycle
    logic pend_last;  // exactly one result is still pending
  } st_t;

endpackage

// ===== design/dfb_ctrl.sv =====
// Controller state machine for the frame buffer flush block.
// Depends on dfb_pkg for the command and status structs.
`timescale 1ns / 1ps

module dfb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,   // func: 0 pixel write, 1 flush step
  output logic          s_tready,
  input  dfb_pkg::st_t  st,
  output dfb_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PIX   = 5'b00100,
    S_EVAL  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Commands follow directly from the state; accept also needs s_tvalid.
  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == S_CLEAR);
    cmd.accept  = accept;
    cmd.pix_wr  = (state == S_PIX);
    cmd.fl_eval = (state == S_EVAL);
    cmd.emit    = (state == S_EMIT);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = s_tuser ? S_EVAL : S_PIX;
      end
      S_PIX: begin
        state_next = S_IDLE;
      end
      S_EVAL: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free && st.pend_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/dfb_datapath.sv =====
// Datapath of the frame buffer flush block: store, cursor, pending results, output register.
// Depends on dfb_pkg for constants and the command and status structs.
`timescale 1ns / 1ps

module dfb_datapath #(
  parameter int PAGES            = dfb_pkg::PAGES_DEF,
  parameter int COLUMNS_PER_CHIP = dfb_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dfb_pkg::cmd_t                 cmd,
  output dfb_pkg::st_t                  st,
  input  logic [dfb_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [dfb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [dfb_pkg::KIND_W-1:0]    m_tuser,
  output logic                          m_tlast
);

  localparam int PanelRows = PAGES * 8;
  localparam int PanelCols = 2 * COLUMNS_PER_CHIP;
  localparam int StoreSize = PAGES * PanelCols;
  localparam int AW        = $clog2(StoreSize);
  localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW        = $clog2(COLUMNS_PER_CHIP);

  // Pending result slots, in emission order.
  localparam int P_PAGE  = 0;
  localparam int P_ADDR  = 1;
  localparam int P_LEFT  = 2;
  localparam int P_RIGHT = 3;
  localparam int P_IDLE  = 4;

  // Input fields.
  logic [7:0] row;
  logic [8:0] column;
  logic       pixel_on;

  assign row      = s_tdata[7:0];
  assign column   = s_tdata[16:8];
  assign pixel_on = s_tdata[17];

  // Control registers.
  logic [AW-1:0] clr_cnt;
  logic [PW-1:0] cur_page;
  logic [CW-1:0] cur_col;
  logic [4:0]    pend;
  logic          clr_r_pend;
  logic          out_valid;

  // Payload registers.
  logic [AW-1:0] pix_idx;
  logic [2:0]    pix_sh;
  logic          pix_on;
  logic          pix_ok;
  logic [AW-1:0] ri_q;
  logic [7:0]    page_val;
  logic [7:0]    addr_val;
  logic [7:0]    l_byte;
  logic [7:0]    r_byte;
  logic          dl_q;
  logic          dr_q;
  logic          done_q;
  logic [15:0]   rd_a;
  logic [15:0]   rd_b;
  logic [1:0]    out_kind;
  logic [7:0]    out_value;
  logic          out_left;
  logic          out_right;
  logic          out_done;
  logic          out_last;

  // Store words: marks in the upper byte, pixels in the lower byte.
  logic [15:0] mem [StoreSize];

  // Combinational signals.
  logic          in_ok;
  logic [7:0]    r_m;
  logic [7:0]    c_m;
  logic [AW-1:0] in_idx;
  logic [AW-1:0] li;
  logic [AW-1:0] ri;
  logic [AW-1:0] raddr_a;
  logic          dl;
  logic          dr;
  logic          col_zero;
  logic          pos_done;
  logic [7:0]    pix_mask;
  logic          pix_change;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          out_free;
  logic          emit_fire;
  logic [4:0]    sel_bit;
  logic [1:0]    sel_kind;
  logic [7:0]    sel_value;
  logic          sel_left;
  logic          sel_right;

  // Bounds check, mirroring and index of a pixel request.
  always_comb begin
    in_ok  = !row[7] && (int'(row[6:0]) < PanelRows) &&
             !column[8] && (int'(column[7:0]) < PanelCols);
    r_m    = 8'(PanelRows - 1 - int'(row[6:0]));
    c_m    = 8'(PanelCols - 1 - int'(column[7:0]));
    in_idx = in_ok ? AW'(int'(r_m[7:3]) * PanelCols + int'(c_m)) : '0;
  end

  // Left and right store indexes of the flush cursor.
  always_comb begin
    li       = AW'(int'(cur_page) * PanelCols + int'(cur_col));
    ri       = AW'(int'(li) + COLUMNS_PER_CHIP);
    raddr_a  = s_tuser ? li : in_idx;
    col_zero = (cur_col == '0);
    pos_done = (cur_page == PW'(PAGES - 1)) && (cur_col == CW'(COLUMNS_PER_CHIP - 1));
    dl       = |rd_a[15:8];
    dr       = |rd_b[15:8];
  end

  // Pixel read-modify-write: toggle pixel and mark only on a change.
  always_comb begin
    pix_mask   = 8'(1) << pix_sh;
    pix_change = pix_ok && (rd_a[pix_sh] != pix_on);
  end

  // Single write port shared by clearing, pixel writes and mark clearing.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.pix_wr && pix_change) begin
      we    = 1'b1;
      waddr = pix_idx;
      wdata = rd_a ^ {pix_mask, pix_mask};
    end else if (cmd.fl_eval && dl) begin
      we    = 1'b1;
      waddr = li;
      wdata = {8'h00, rd_a[7:0]};
    end else if (cmd.emit && clr_r_pend) begin
      we    = 1'b1;
      waddr = ri_q;
      wdata = {8'h00, r_byte};
    end
  end

  // Store with two registered read ports.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[ri];
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Latch a pixel request at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_idx <= in_idx;
      pix_sh  <= r_m[2:0];
      pix_on  <= pixel_on;
      pix_ok  <= in_ok;
    end
  end

  // Cursor advances once per flush step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_page <= '0;
      cur_col  <= '0;
    end else if (cmd.fl_eval) begin
      if (cur_col == CW'(COLUMNS_PER_CHIP - 1)) begin
        cur_col <= '0;
        if (cur_page == PW'(PAGES - 1)) begin
          cur_page <= '0;
        end else begin
          cur_page <= cur_page + PW'(1);
        end
      end else begin
        cur_col <= cur_col + CW'(1);
      end
    end
  end

  // Result bytes of the flush step.
  always_ff @(posedge clk) begin
    if (cmd.fl_eval) begin
      page_val <= dfb_pkg::CMD_SET_PAGE | {5'b00000, 3'(cur_page)};
      addr_val <= dfb_pkg::CMD_SET_ADDR | {2'b00, 6'(cur_col)};
      l_byte   <= rd_a[7:0];
      r_byte   <= rd_b[7:0];
      dl_q     <= dl;
      dr_q     <= dr;
      done_q   <= pos_done;
      ri_q     <= ri;
    end
  end

  // Pick the first pending result.
  always_comb begin
    out_free  = !out_valid || m_tready;
    emit_fire = cmd.emit && out_free && (|pend);
    sel_bit   = pend & (~pend + 5'd1);
    sel_kind  = dfb_pkg::KIND_IDLE;
    sel_value = 8'h00;
    sel_left  = 1'b0;
    sel_right = 1'b0;
    if (pend[P_PAGE]) begin
      sel_kind  = dfb_pkg::KIND_CMD;
      sel_value = page_val;
      sel_left  = 1'b1;
      sel_right = 1'b1;
    end else if (pend[P_ADDR]) begin
      sel_kind  = dfb_pkg::KIND_CMD;
      sel_value = addr_val;
      sel_left  = dl_q;
      sel_right = dr_q;
    end else if (pend[P_LEFT]) begin
      sel_kind  = dfb_pkg::KIND_DATA;
      sel_value = l_byte;
      sel_left  = 1'b1;
    end else if (pend[P_RIGHT]) begin
      sel_kind  = dfb_pkg::KIND_DATA;
      sel_value = r_byte;
      sel_right = 1'b1;
    end
  end

  // Pending result flags and the deferred clear of the right mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= '0;
      clr_r_pend <= 1'b0;
    end else if (cmd.fl_eval) begin
      pend[P_PAGE]  <= col_zero;
      pend[P_ADDR]  <= dl || dr;
      pend[P_LEFT]  <= dl;
      pend[P_RIGHT] <= dr;
      pend[P_IDLE]  <= !(col_zero || dl || dr);
      clr_r_pend    <= dr;
    end else begin
      if (emit_fire) pend <= pend & ~sel_bit;
      if (cmd.emit) clr_r_pend <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_kind  <= sel_kind;
      out_value <= sel_value;
      out_left  <= sel_left;
      out_right <= sel_right;
      out_done  <= done_q;
      out_last  <= $onehot(pend);
    end
  end

  assign st.clr_done  = (clr_cnt == AW'(StoreSize - 1));
  assign st.out_free  = out_free;
  assign st.pend_last = $onehot(pend);

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_done, out_right, out_left, out_value};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

// ===== design/dirty_framebuffer_flush_top.sv =====
// Pixel write: accepted, written in the next cycle; s_tready stays low until the write is done.
// Flush step: the first result is registered in S_EMIT after S_EVAL; one result per cycle follows
// while m_tready is high, one to four results per step.
// Synchronous reset clears the cursor and the output stage, then a clearing pass writes zero
// to every store word, PAGES*2*COLUMNS_PER_CHIP words (1024 by default), with s_tready low.
// Top level of the frame buffer flush block; depends on dfb_pkg, dfb_ctrl and dfb_datapath.
`timescale 1ns / 1ps

module dirty_framebuffer_flush_top #(
  parameter int PAGES            = dfb_pkg::PAGES_DEF,
  parameter int COLUMNS_PER_CHIP = dfb_pkg::COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dfb_pkg::IN_DATA_W-1:0]  s_tdata,   // row[7:0], column[16:8], pixel_on[17]
  input  logic                           s_tuser,   // func[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dfb_pkg::OUT_DATA_W-1:0] m_tdata,   // value[7:0], to_left[8], to_right[9],
                                                    // pass_done[10]
  output logic [dfb_pkg::KIND_W-1:0]     m_tuser,   // kind[1:0]
  output logic                           m_tlast
);

  dfb_pkg::cmd_t cmd;
  dfb_pkg::st_t  st;

  // Sequencing of each request.
  dfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Store, cursor and result path.
  dfb_datapath #(
    .PAGES            (PAGES),
    .COLUMNS_PER_CHIP (COLUMNS_PER_CHIP)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/dfb_checker.sv =====
// Port-level checks of the frame buffer flush block, bound to the top level.
// Depends on dfb_pkg for the result kind codes.
`timescale 1ns / 1ps

module dfb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dfb_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [dfb_pkg::KIND_W-1:0]     m_tuser,
  input logic                           m_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("result changed while stalled");

  // An idle step gives a single, empty result.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dfb_pkg::KIND_IDLE) |-> (m_tdata[9:0] == 10'd0) && m_tlast)
    else $error("idle result not empty or not last");

  // A data byte goes to exactly one controller.
  a_data_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dfb_pkg::KIND_DATA) |-> (m_tdata[8] ^ m_tdata[9]))
    else $error("data byte not routed to exactly one controller");

  // A command always reaches a controller and is never the last result of a step unless it sets the page.
  a_cmd_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dfb_pkg::KIND_CMD) |-> (m_tdata[8] || m_tdata[9]) &&
    (!m_tlast || (m_tdata[7:3] == dfb_pkg::CMD_SET_PAGE[7:3])))
    else $error("command result misrouted or ends a step");

  // The input side is never ready while a pixel write is finishing.
  a_pix_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("request taken during a pixel write");

endmodule

bind dirty_framebuffer_flush_top dfb_checker u_dfb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
